@@ src/ois_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ois_pkg: shared types and constants for the ordered integer set
// universe of 2^16 values, leaf bitmap 1024x64, middle summary 16x64, top 16
// ----------------------------------------------------------------------------
package ois_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned LeafAw = 10;
  localparam int unsigned MidAw = 4;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_SUCC   = 3'd3,
    OP_PRED   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_ABSENT    = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] element;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] neighbour_value;
    logic        is_member;
    logic [15:0] set_minimum;
    logic [15:0] set_maximum;
    logic        set_empty;
    logic [1:0]  status;
  } out_item_t;

  // lowest set bit index, word known nonzero
  function automatic logic [5:0] low_bit(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] high_bit(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] low_bit16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] high_bit16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // mask of bits at or above p
  function automatic logic [63:0] mask_up(input logic [5:0] p);
    return {64{1'b1}} << p;
  endfunction

  // mask of bits at or below p
  function automatic logic [63:0] mask_dn(input logic [5:0] p);
    return {64{1'b1}} >> (6'd63 - p);
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // leaf and middle words at the element
    S_UPD,     // write back, decide search path
    S_MRD,     // middle word chosen by top summary
    S_MSEL,    // pick leaf word from middle word
    S_LRD,     // leaf word chosen by middle summary
    S_LSEL,    // pick value
    S_OUT
  } state_e;

endpackage

@@ src/ordered_integer_set_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_integer_set_core: ordered integer set over 0..65535
// leaf bitmap and middle summary in synchronous memories, top summary in flops
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i, in_ready_o, in_item_i
// out     | output    | out_valid_o, out_ready_i, out_item_o
//
// insert, member test and unknown codes: read at accept, then S_UPD and S_OUT.
// successor or predecessor: answered in S_UPD when found in the word, via
// S_LRD and S_LSEL from the middle word, or via S_MRD, S_MSEL, S_LRD and S_LSEL
// from the top summary; a delete of min or max runs one such search. one item
// at a time; in_ready_o is low while an item runs or while a result waits.
// after reset a clearing pass zeroes every leaf and middle word first.
module ordered_integer_set_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ois_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ois_pkg::out_item_t  out_item_o
);

  logic [63:0] leaf_mem [1024];
  logic [63:0] mid_mem  [16];

  ois_pkg::state_e state_q, state_d;
  logic [10:0] clr_q, clr_d;
  logic        clr_busy;

  logic [2:0]  op_q, op_d;
  logic [15:0] x_q, x_d;
  logic [15:0] top_q, top_d;
  logic [15:0] min_q, min_d, max_q, max_d;
  logic        empty_q, empty_d;
  logic        member_q, member_d;
  logic        found_q, found_d;
  logic [15:0] nb_q, nb_d;
  logic [1:0]  status_q, status_d;
  logic        up_q, up_d;        // search direction
  logic        minfix_q, minfix_d; // after delete: fix minimum too
  logic        maxfix_q, maxfix_d;
  logic [9:0]  lword_q, lword_d;   // chosen leaf word

  logic        leaf_we, mid_we;
  logic [9:0]  leaf_wa, leaf_ra;
  logic [3:0]  mid_wa, mid_ra;
  logic [63:0] leaf_wd, mid_wd, leaf_rd_q, mid_rd_q;
  logic        out_valid_q, out_valid_d;

  assign clr_busy = !clr_q[10];

  always_ff @(posedge clk_i) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    leaf_rd_q <= leaf_mem[leaf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) mid_mem[mid_wa] <= mid_wd;
    mid_rd_q <= mid_mem[mid_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ois_pkg::S_IDLE;
      clr_q <= '0;
      top_q <= '0;
      min_q <= '0;
      max_q <= '0;
      empty_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      top_q <= top_d;
      min_q <= min_d;
      max_q <= max_d;
      empty_q <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    x_q <= x_d;
    member_q <= member_d;
    found_q <= found_d;
    nb_q <= nb_d;
    status_q <= status_d;
    up_q <= up_d;
    minfix_q <= minfix_d;
    maxfix_q <= maxfix_d;
    lword_q <= lword_d;
  end

  assign in_ready_o = (state_q == ois_pkg::S_IDLE) && !clr_busy && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    out_item_o.found = found_q;
    out_item_o.neighbour_value = nb_q;
    out_item_o.is_member = member_q;
    out_item_o.set_minimum = empty_q ? 16'd0 : min_q;
    out_item_o.set_maximum = empty_q ? 16'd0 : max_q;
    out_item_o.set_empty = empty_q;
    out_item_o.status = status_q;
  end

  logic [9:0]  lw;
  logic [3:0]  mw;
  logic [5:0]  xb, lb;
  logic [63:0] leaf_new, mid_new, wl, wm;
  logic [15:0] tmask;
  logic        search;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    op_d = op_q;
    x_d = x_q;
    top_d = top_q;
    min_d = min_q;
    max_d = max_q;
    empty_d = empty_q;
    member_d = member_q;
    found_d = found_q;
    nb_d = nb_q;
    status_d = status_q;
    up_d = up_q;
    minfix_d = minfix_q;
    maxfix_d = maxfix_q;
    lword_d = lword_q;
    out_valid_d = out_valid_q;
    leaf_we = 1'b0;
    mid_we = 1'b0;
    leaf_wa = x_q[15:6];
    mid_wa = x_q[15:12];
    leaf_wd = '0;
    mid_wd = '0;
    leaf_ra = x_q[15:6];
    mid_ra = x_q[15:12];
    lw = x_q[15:6];
    mw = x_q[15:12];
    xb = x_q[5:0];
    lb = x_q[11:6];
    leaf_new = leaf_rd_q;
    mid_new = mid_rd_q;
    wl = '0;
    wm = '0;
    tmask = '0;
    search = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (clr_busy) begin
      leaf_we = 1'b1;
      leaf_wa = clr_q[9:0];
      mid_we = 1'b1;
      mid_wa = clr_q[3:0];
      clr_d = clr_q + 11'd1;
    end

    case (state_q)
      ois_pkg::S_IDLE: begin
        leaf_ra = in_item_i.element[15:6];
        mid_ra = in_item_i.element[15:12];
        if (in_valid_i && in_ready_o) begin
          op_d = in_item_i.operation;
          x_d = in_item_i.element;
          found_d = 1'b0;
          nb_d = '0;
          status_d = ois_pkg::ST_OK;
          minfix_d = 1'b0;
          maxfix_d = 1'b0;
          state_d = ois_pkg::S_UPD;
        end
      end
      ois_pkg::S_UPD: begin
        member_d = leaf_rd_q[xb];
        state_d = ois_pkg::S_OUT;
        if (op_q == ois_pkg::OP_INSERT) begin
          if (leaf_rd_q[xb]) begin
            status_d = ois_pkg::ST_DUP;
          end else begin
            leaf_we = 1'b1;
            leaf_wd = leaf_rd_q | (64'd1 << xb);
            mid_we = 1'b1;
            mid_wd = mid_rd_q | (64'd1 << lb);
            top_d = top_q | (16'd1 << mw);
            if (empty_q) begin
              min_d = x_q;
              max_d = x_q;
              empty_d = 1'b0;
            end else begin
              if (x_q < min_q) min_d = x_q;
              if (x_q > max_q) max_d = x_q;
            end
          end
        end else if (op_q == ois_pkg::OP_DELETE) begin
          if (!leaf_rd_q[xb]) begin
            status_d = ois_pkg::ST_ABSENT;
          end else begin
            leaf_new = leaf_rd_q & ~(64'd1 << xb);
            leaf_we = 1'b1;
            leaf_wd = leaf_new;
            if (leaf_new == '0) begin
              mid_new = mid_rd_q & ~(64'd1 << lb);
              mid_we = 1'b1;
              mid_wd = mid_new;
              if (mid_new == '0) top_d = top_q & ~(16'd1 << mw);
            end
            if (min_q == max_q) begin
              min_d = '0;
              max_d = '0;
              empty_d = 1'b1;
            end else if (x_q == min_q) begin
              // next minimum: successor of x, which exists
              minfix_d = 1'b1;
              maxfix_d = (x_q == max_q);
              up_d = 1'b1;
              search = 1'b1;
              wl = leaf_new & mask_up_p1(xb);
              wm = (lb == 6'd63) ? '0 : (mid_new & (ois_pkg::mask_up(lb) << 1));
            end else if (x_q == max_q) begin
              maxfix_d = 1'b1;
              up_d = 1'b0;
              search = 1'b1;
              wl = leaf_new & mask_dn_m1(xb);
              wm = (lb == 6'd0) ? '0 : (mid_new & (ois_pkg::mask_dn(lb) >> 1));
            end
          end
        end else if (op_q == ois_pkg::OP_SUCC) begin
          up_d = 1'b1;
          search = (x_q != 16'hFFFF);
          wl = leaf_rd_q & mask_up_p1(xb);
          wm = (lb == 6'd63) ? '0 : (mid_rd_q & (ois_pkg::mask_up(lb) << 1));
        end else if (op_q == ois_pkg::OP_PRED) begin
          up_d = 1'b0;
          search = (x_q != 16'd0);
          wl = leaf_rd_q & mask_dn_m1(xb);
          wm = (lb == 6'd0) ? '0 : (mid_rd_q & (ois_pkg::mask_dn(lb) >> 1));
        end
        if (search) begin
          if (up_d) tmask = (mw == 4'd15) ? '0 : ((16'hFFFF << mw) << 1);
          else      tmask = (mw == 4'd0) ? '0 : ((16'hFFFF >> (4'd15 - mw)) >> 1);
          if (wl != '0) begin
            result(up_d ? {lw, ois_pkg::low_bit(wl)} : {lw, ois_pkg::high_bit(wl)});
          end else if (wm != '0) begin
            lword_d = up_d ? {mw, ois_pkg::low_bit(wm)} : {mw, ois_pkg::high_bit(wm)};
            state_d = ois_pkg::S_LRD;
          end else if ((top_d & tmask) != '0) begin
            mid_ra = up_d ? ois_pkg::low_bit16(top_d & tmask)
                          : ois_pkg::high_bit16(top_d & tmask);
            lword_d = {mid_ra, 6'd0};
            state_d = ois_pkg::S_MRD;
          end
        end
      end
      ois_pkg::S_MRD: begin
        // hold the chosen middle word on the read port
        mid_ra = lword_q[9:6];
        state_d = ois_pkg::S_MSEL;
      end
      ois_pkg::S_MSEL: begin
        lword_d = {lword_q[9:6],
                   up_q ? ois_pkg::low_bit(mid_rd_q) : ois_pkg::high_bit(mid_rd_q)};
        state_d = ois_pkg::S_LRD;
      end
      ois_pkg::S_LRD: begin
        leaf_ra = lword_q;
        state_d = ois_pkg::S_LSEL;
      end
      ois_pkg::S_LSEL: begin
        result({lword_q,
                up_q ? ois_pkg::low_bit(leaf_rd_q) : ois_pkg::high_bit(leaf_rd_q)});
        state_d = ois_pkg::S_OUT;
      end
      ois_pkg::S_OUT: begin
        out_valid_d = 1'b1;
        state_d = ois_pkg::S_IDLE;
      end
      default: state_d = ois_pkg::S_IDLE;
    endcase
  end

  // bits strictly above / below p
  function automatic logic [63:0] mask_up_p1(input logic [5:0] p);
    return (p == 6'd63) ? 64'd0 : (ois_pkg::mask_up(p) << 1);
  endfunction

  function automatic logic [63:0] mask_dn_m1(input logic [5:0] p);
    return (p == 6'd0) ? 64'd0 : (ois_pkg::mask_dn(p) >> 1);
  endfunction

  // a found value either repairs min/max after delete or answers a search
  function automatic void result(input logic [15:0] v);
    if (op_q == ois_pkg::OP_DELETE) begin
      if (minfix_d) min_d = v;
      if (maxfix_d && !minfix_d) max_d = v;
    end else begin
      found_d = 1'b1;
      nb_d = v;
    end
    state_d = ois_pkg::S_OUT;
  endfunction

endmodule
